// ----- hdl/cdf_table_sample_binner_assert.svh -----
// Assertion macros used by the sampler's back end (cdf_back).
// Depends on clock and reset signals named clock and reset in the including module.
`ifndef CDF_TABLE_SAMPLE_BINNER_ASSERT_SVH
`define CDF_TABLE_SAMPLE_BINNER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CDF_ASSERT_IMPLY(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("cdf same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CDF_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("cdf next-cycle check failed");

`endif

// ----- hdl/cdf_pkg.sv -----
// Shared widths, codes, defaults and types of the inverse-CDF sampler.
// No dependencies.
package cdf_pkg;
   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int WEIGHT_BITS_DEF = 24;

   localparam int CMD_W      = 2;
   localparam int IDX_W      = 10;
   localparam int VALUE_W    = 24;
   localparam int BIN_W      = 10;
   localparam int CNT_W      = 32;
   localparam int ENTRIES_W  = 11;
   localparam int LIMIT_W    = 10;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ENTRIES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT   = 1'd1;

   localparam logic [ENTRIES_W-1:0] ENTRIES_RST = 11'd601;
   localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 10'd200;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [IDX_W-1:0]   index;
      logic               in_range;
      logic [VALUE_W-1:0] weight;
      logic               zero;
   } item_type;

   typedef struct packed {
      logic [ENTRIES_W-1:0] entries;
      logic [LIMIT_W-1:0]   limit;
   } cfg_type;
endpackage

// ----- hdl/cdf_chan_if.sv -----
// Valid/ready channel interfaces for sampler requests and responses.
// Depends on cdf_pkg for field widths.
interface cdf_req_if;
   logic                          valid;
   logic                          ready;
   logic [cdf_pkg::CMD_W-1:0]     cmd;
   logic [cdf_pkg::IDX_W-1:0]     index;
   logic [cdf_pkg::VALUE_W-1:0]   value;

   modport source (output valid, output cmd, output index, output value, input ready);
   modport sink   (input valid, input cmd, input index, input value, output ready);
endinterface

interface cdf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cdf_pkg::BIN_W-1:0]     bin;
   logic                          found;
   logic                          is_error;
   logic [cdf_pkg::CNT_W-1:0]     error_total;
   logic [cdf_pkg::CNT_W-1:0]     bin_count;

   modport source (output valid, output bin, output found, output is_error,
                   output error_total, output bin_count, input ready);
   modport sink   (input valid, input bin, input found, input is_error,
                   input error_total, input bin_count, output ready);
endinterface

// ----- hdl/cdf_table_sample_binner.sv -----
// Inverse-CDF table sampler with histogram. Commands arrive on req_if (valid/ready): load a
// cumulative table entry, draw a sample, or read a histogram bin; each command gives exactly
// one beat on rsp_if. After reset the block clears its TABLE_DEPTH-entry histogram, one bin
// a cycle, and takes no request until the clear is done; csr_ writes are taken at any
// time and must be issued only while the block is idle. Loads and reads go from the queue
// head through ST_FIN to the result register, a zero sample through ST_HRD, ST_HWR and
// ST_FIN. A sample walks the table memory one entry per cycle from entry 0, up to entry
// s + 1 for section s or to the last entry in use if not found; the single read port of the
// table memory sets that pace. A two-entry queue separates request intake from execution.
// Depends on cdf_pkg, cdf_chan_if, cdf_front, cdf_queue and cdf_back.
module cdf_table_sample_binner #(
   parameter int TABLE_DEPTH = cdf_pkg::TABLE_DEPTH_DEF,
   parameter int WEIGHT_BITS = cdf_pkg::WEIGHT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [cdf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cdf_pkg::CSR_DATA_W-1:0]    csr_wdata,
   cdf_req_if.sink                           req_if,
   cdf_rsp_if.source                         rsp_if
);
   cdf_pkg::cfg_type  cfg_ff, cfg_in;
   cdf_pkg::item_type push_item, head_item;
   logic              push, q_full, q_pop, q_empty, accept_en;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            cdf_pkg::CSR_ENTRIES: cfg_in.entries = csr_wdata;
            cdf_pkg::CSR_LIMIT:   cfg_in.limit   = csr_wdata[cdf_pkg::LIMIT_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.entries <= cdf_pkg::ENTRIES_RST;
         cfg_ff.limit   <= cdf_pkg::LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cdf_front #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_front (
      .req_if    (req_if),
      .accept_en (accept_en),
      .q_full    (q_full),
      .push      (push),
      .push_item (push_item)
   );

   cdf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .head      (head_item),
      .empty     (q_empty)
   );

   cdf_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_item    (head_item),
      .q_pop     (q_pop),
      .accept_en (accept_en),
      .rsp_if    (rsp_if)
   );
endmodule

// ----- hdl/cdf_front.sv -----
// Request front end: accepts beats, masks the weight and flags an out-of-range index and a zero weight.
// Depends on cdf_pkg and cdf_req_if.
module cdf_front #(
   parameter int TABLE_DEPTH = cdf_pkg::TABLE_DEPTH_DEF,
   parameter int WEIGHT_BITS = cdf_pkg::WEIGHT_BITS_DEF
) (
   cdf_req_if.sink             req_if,
   input  logic                accept_en,
   input  logic                q_full,
   output logic                push,
   output cdf_pkg::item_type   push_item
);
   localparam bit ALL_IN = (TABLE_DEPTH >= (1 << cdf_pkg::IDX_W));

   logic [cdf_pkg::VALUE_W-1:0] weight;

   assign weight = cdf_pkg::VALUE_W'(WEIGHT_BITS'(req_if.value));

   assign req_if.ready = accept_en && !q_full;
   assign push         = req_if.valid && req_if.ready;

   always_comb begin
      push_item.cmd      = req_if.cmd;
      push_item.index    = req_if.index;
      push_item.in_range = ALL_IN || (req_if.index < cdf_pkg::IDX_W'(TABLE_DEPTH));
      push_item.weight   = weight;
      push_item.zero     = (weight == '0);
   end
endmodule

// ----- hdl/cdf_queue.sv -----
// Short FIFO of classified items between the front end and the execution back end.
// Depends on cdf_pkg.
module cdf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cdf_pkg::item_type  push_item,
   output logic               full,
   input  logic               pop,
   output cdf_pkg::item_type  head,
   output logic               empty
);
   localparam int PW = (cdf_pkg::QPTR_W > 0) ? cdf_pkg::QPTR_W : 1;

   cdf_pkg::item_type slot_ff [cdf_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == (PW+1)'(cdf_pkg::QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(cdf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(cdf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end
endmodule

// ----- hdl/cdf_back.sv -----
// Execution back end: histogram clear, table writes, section walk, histogram update and read, result register.
// Depends on cdf_pkg, cdf_rsp_if and the assertion macro header.
`include "cdf_table_sample_binner_assert.svh"

module cdf_back #(
   parameter int TABLE_DEPTH = cdf_pkg::TABLE_DEPTH_DEF,
   parameter int WEIGHT_BITS = cdf_pkg::WEIGHT_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cdf_pkg::cfg_type   cfg,
   input  logic               q_empty,
   input  cdf_pkg::item_type  q_item,
   output logic               q_pop,
   output logic               accept_en,
   cdf_rsp_if.source          rsp_if
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int NW = $clog2(TABLE_DEPTH + 1);
   localparam int MW = (cdf_pkg::ENTRIES_W > NW) ? cdf_pkg::ENTRIES_W : NW;
   localparam int XW = (AW > cdf_pkg::LIMIT_W) ? AW : cdf_pkg::LIMIT_W;
   localparam int CW = cdf_pkg::CNT_W;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_HRD   = 3'd3;
   localparam logic [2:0] ST_HWR   = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] x);
      return (x == '1) ? x : x + 1'b1;
   endfunction

   logic [WEIGHT_BITS-1:0] tbl_mem [TABLE_DEPTH];
   logic [CW-1:0]          hist_mem [TABLE_DEPTH];

   logic [2:0]              state_ff, state_in;
   logic [AW-1:0]           clr_ff, clr_in;
   logic [AW-1:0]           k_ff, k_in;
   logic [AW-1:0]           last_ff, last_in;
   logic [AW-1:0]           sect_ff, sect_in;
   logic                    found_ff, found_in;
   cdf_pkg::item_type       item_ff, item_in;
   logic [WEIGHT_BITS-1:0]  prev_ff, prev_in;
   logic [CW-1:0]           err_ff, err_in;
   logic [WEIGHT_BITS-1:0]  tbl_rd_ff;
   logic [CW-1:0]           hist_rd_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [cdf_pkg::BIN_W-1:0] out_bin_ff, out_bin_in;
   logic                    out_found_ff, out_found_in;
   logic                    out_err_ff, out_err_in;
   logic [CW-1:0]           out_total_ff, out_total_in;
   logic [CW-1:0]           out_count_ff, out_count_in;

   logic                    tbl_we;
   logic [AW-1:0]           tbl_raddr;
   logic                    hist_we, hist_re;
   logic [AW-1:0]           hist_waddr, hist_raddr;
   logic [CW-1:0]           hist_wdata;

   logic [MW-1:0]           n_mw;
   logic                    too_few;
   logic [WEIGHT_BITS-1:0]  cur_w;
   logic                    hit;
   logic                    slot_free;
   logic                    is_sample;
   logic                    is_err;

   assign n_mw = (MW'(cfg.entries) > MW'(TABLE_DEPTH)) ? MW'(TABLE_DEPTH) : MW'(cfg.entries);
   assign too_few   = (n_mw < MW'(2));
   assign cur_w     = WEIGHT_BITS'(item_ff.weight);
   assign hit       = (prev_ff <= cur_w) && (cur_w < tbl_rd_ff);
   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign is_sample = (item_ff.cmd == cdf_pkg::CMD_SAMPLE);
   assign is_err    = is_sample && (!found_ff || (XW'(sect_ff) <= XW'(cfg.limit)));
   assign accept_en = !reset && (state_ff != ST_CLEAR);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      k_in         = k_ff;
      last_in      = last_ff;
      sect_in      = sect_ff;
      found_in     = found_ff;
      item_in      = item_ff;
      prev_in      = prev_ff;
      err_in       = err_ff;
      q_pop        = 1'b0;
      tbl_we       = 1'b0;
      tbl_raddr    = '0;
      hist_we      = 1'b0;
      hist_waddr   = sect_ff;
      hist_wdata   = sat_inc(hist_rd_ff);
      hist_re      = 1'b0;
      hist_raddr   = sect_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      out_bin_in   = out_bin_ff;
      out_found_in = out_found_ff;
      out_err_in   = out_err_ff;
      out_total_in = out_total_ff;
      out_count_in = out_count_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            hist_we    = 1'b1;
            hist_waddr = clr_ff;
            hist_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == AW'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               k_in     = '0;
               sect_in  = '0;
               found_in = 1'b0;
               last_in  = AW'(n_mw - MW'(1));
               state_in = ST_FIN;
               unique case (q_item.cmd)
                  cdf_pkg::CMD_LOAD: begin
                     tbl_we = q_item.in_range;
                  end
                  cdf_pkg::CMD_SAMPLE: begin
                     if (too_few) begin
                        state_in = ST_FIN;
                     end else if (q_item.zero) begin
                        found_in = 1'b1;
                        state_in = ST_HRD;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  cdf_pkg::CMD_READ: begin
                     hist_re    = q_item.in_range;
                     hist_raddr = AW'(q_item.index);
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            tbl_raddr = k_ff + 1'b1;
            if (k_ff == '0) begin
               prev_in = tbl_rd_ff;
               k_in    = k_ff + 1'b1;
            end else if (hit) begin
               found_in = 1'b1;
               sect_in  = k_ff - 1'b1;
               state_in = ST_HRD;
            end else if (k_ff == last_ff) begin
               state_in = ST_FIN;
            end else begin
               prev_in = tbl_rd_ff;
               k_in    = k_ff + 1'b1;
            end
         end
         ST_HRD: begin
            hist_re  = 1'b1;
            state_in = ST_HWR;
         end
         ST_HWR: begin
            hist_we  = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               err_in       = is_err ? sat_inc(err_ff) : err_ff;
               out_bin_in   = cdf_pkg::BIN_W'(sect_ff);
               out_found_in = found_ff;
               out_err_in   = is_err;
               out_total_in = is_err ? sat_inc(err_ff) : err_ff;
               out_count_in = ((item_ff.cmd == cdf_pkg::CMD_READ) && item_ff.in_range)
                              ? hist_rd_ff : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         err_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      last_ff      <= last_in;
      sect_ff      <= sect_in;
      found_ff     <= found_in;
      item_ff      <= item_in;
      prev_ff      <= prev_in;
      out_bin_ff   <= out_bin_in;
      out_found_ff <= out_found_in;
      out_err_ff   <= out_err_in;
      out_total_ff <= out_total_in;
      out_count_ff <= out_count_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[AW'(q_item.index)] <= WEIGHT_BITS'(q_item.weight);
      end
      tbl_rd_ff <= tbl_mem[tbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      if (hist_re) begin
         hist_rd_ff <= hist_mem[hist_raddr];
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.bin         = out_bin_ff;
   assign rsp_if.found       = out_found_ff;
   assign rsp_if.is_error    = out_err_ff;
   assign rsp_if.error_total = out_total_ff;
   assign rsp_if.bin_count   = out_count_ff;

   `CDF_ASSERT_IMPLY(a_scan_in_bounds, state_ff == ST_SCAN, k_ff <= last_ff)
   `CDF_ASSERT_IMPLY(a_bin_below_last, state_ff == ST_HWR, sect_ff < last_ff)
   `CDF_ASSERT_NEXT(a_rsp_from_fin, (state_ff != ST_FIN) && !rsp_valid_ff, !rsp_valid_ff)
   `CDF_ASSERT_NEXT(a_err_monotonic, 1'b1, err_ff >= $past(err_ff))
endmodule
